FILE: src/ssk_pkg.sv
// Shared types, widths and codes for the subarray sum counter.
package ssk_pkg;

    // Sizing of the element buffer and the arithmetic.
    localparam int MAX_LENGTH = 1024;
    localparam int VALUE_BITS = 8;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int IDX_W      = ADDR_W + 1;
    localparam int TARGET_W   = 18;
    localparam int SUM_W      = 19;
    localparam int COUNT_W    = 20;

    // Register map: word index taken from paddr[2].
    localparam int  PADDR_W    = 3;
    localparam int  PDATA_W    = 32;
    localparam logic REG_TARGET = 1'b0;

    // One input beat.
    typedef struct packed {
        logic [VALUE_BITS-1:0] element;
        logic                  is_last;
    } elem_t;

    // One result beat.
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               overflow;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // store the element and add it to each running window
        logic ovf;       // buffer full: mark overflow
        logic sub;       // drop the left element of each window that is over
        logic count;     // accumulate window spans and advance the index
        logic emit;      // load the result register and clear the sequence
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic room;      // buffer still has space for this element
        logic need_a;    // at-most-k window must shrink
        logic need_b;    // below-k window must shrink
        logic out_busy;  // result register holds an untaken beat
    } status_t;

endpackage

FILE: src/ssk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/ssk_datapath.sv
// Window sums, left edges, counts, element buffers and the result register.
module ssk_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssk_pkg::cmd_t                  cmd,
    output ssk_pkg::status_t               status,
    input  logic [ssk_pkg::VALUE_BITS-1:0] element,
    input  logic [ssk_pkg::TARGET_W-1:0]   target_sum,
    output logic                           result_valid,
    input  logic                           result_ready,
    output ssk_pkg::result_t               result_data
);

    logic [ssk_pkg::IDX_W-1:0]      write_index_reg, write_index_next;
    logic [ssk_pkg::IDX_W-1:0]      left_a_reg, left_a_next;
    logic [ssk_pkg::IDX_W-1:0]      left_b_reg, left_b_next;
    logic [ssk_pkg::SUM_W-1:0]      sum_a_reg, sum_a_next;
    logic [ssk_pkg::SUM_W-1:0]      sum_b_reg, sum_b_next;
    logic [ssk_pkg::COUNT_W-1:0]    count_a_reg, count_a_next;
    logic [ssk_pkg::COUNT_W-1:0]    count_b_reg, count_b_next;
    logic                           overflow_reg, overflow_next;
    logic                           valid_reg, valid_next;
    ssk_pkg::result_t               result_reg, result_next;

    logic                           run_b;
    logic [ssk_pkg::SUM_W-1:0]      limit_a;
    logic [ssk_pkg::SUM_W-1:0]      limit_b;
    logic [ssk_pkg::VALUE_BITS-1:0] rdata_a;
    logic [ssk_pkg::VALUE_BITS-1:0] rdata_b;
    logic [ssk_pkg::IDX_W-1:0]      span_a;
    logic [ssk_pkg::IDX_W-1:0]      span_b;
    logic [ssk_pkg::COUNT_W-1:0]    diff;

    // One buffer copy per window so both left edges read in the same cycle.
    ssk_ram #(
        .WIDTH (ssk_pkg::VALUE_BITS),
        .DEPTH (ssk_pkg::MAX_LENGTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (write_index_reg[ssk_pkg::ADDR_W-1:0]),
        .wdata (element),
        .raddr (left_a_reg[ssk_pkg::ADDR_W-1:0]),
        .rdata (rdata_a)
    );

    ssk_ram #(
        .WIDTH (ssk_pkg::VALUE_BITS),
        .DEPTH (ssk_pkg::MAX_LENGTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (write_index_reg[ssk_pkg::ADDR_W-1:0]),
        .wdata (element),
        .raddr (left_b_reg[ssk_pkg::ADDR_W-1:0]),
        .rdata (rdata_b)
    );

    // Limits of the two windows; the below-k window only runs for a nonzero target.
    assign run_b   = (target_sum != '0);
    assign limit_a = ssk_pkg::SUM_W'(target_sum);
    assign limit_b = ssk_pkg::SUM_W'(target_sum) - ssk_pkg::SUM_W'(1);

    // Shrink conditions; the newest element sits at write_index until counted.
    assign status.need_a   = (sum_a_reg > limit_a) && (left_a_reg <= write_index_reg);
    assign status.need_b   = run_b && (sum_b_reg > limit_b)
                             && (left_b_reg <= write_index_reg);
    assign status.room     = (write_index_reg < ssk_pkg::IDX_W'(ssk_pkg::MAX_LENGTH));
    assign status.out_busy = valid_reg && !result_ready;

    // Number of windows that end at the newest element.
    assign span_a = write_index_reg + ssk_pkg::IDX_W'(1) - left_a_reg;
    assign span_b = write_index_reg + ssk_pkg::IDX_W'(1) - left_b_reg;

    // Final count, modulo the output width.
    assign diff = run_b ? (count_a_reg - count_b_reg) : count_a_reg;

    // Next-state logic for the windows and the result register.
    always_comb
    begin
        write_index_next = write_index_reg;
        left_a_next      = left_a_reg;
        left_b_next      = left_b_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        count_a_next     = count_a_reg;
        count_b_next     = count_b_reg;
        overflow_next    = overflow_reg;
        valid_next       = valid_reg;
        result_next      = result_reg;

        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            sum_a_next = sum_a_reg + ssk_pkg::SUM_W'(element);
            if (run_b)
            begin
                sum_b_next = sum_b_reg + ssk_pkg::SUM_W'(element);
            end
        end

        if (cmd.ovf)
        begin
            overflow_next = 1'b1;
        end

        if (cmd.sub)
        begin
            if (status.need_a)
            begin
                sum_a_next  = sum_a_reg - ssk_pkg::SUM_W'(rdata_a);
                left_a_next = left_a_reg + ssk_pkg::IDX_W'(1);
            end
            if (status.need_b)
            begin
                sum_b_next  = sum_b_reg - ssk_pkg::SUM_W'(rdata_b);
                left_b_next = left_b_reg + ssk_pkg::IDX_W'(1);
            end
        end

        if (cmd.count)
        begin
            count_a_next = count_a_reg + ssk_pkg::COUNT_W'(span_a);
            if (run_b)
            begin
                count_b_next = count_b_reg + ssk_pkg::COUNT_W'(span_b);
            end
            write_index_next = write_index_reg + ssk_pkg::IDX_W'(1);
        end

        if (cmd.emit)
        begin
            result_next.match_count = diff;
            result_next.overflow    = overflow_reg;
            valid_next              = 1'b1;
            write_index_next        = '0;
            left_a_next             = '0;
            left_b_next             = '0;
            sum_a_next              = '0;
            sum_b_next              = '0;
            count_a_next            = '0;
            count_b_next            = '0;
            overflow_next           = 1'b0;
        end
    end

    // Sequence state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            left_a_reg      <= '0;
            left_b_reg      <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            count_a_reg     <= '0;
            count_b_reg     <= '0;
            overflow_reg    <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            left_a_reg      <= left_a_next;
            left_b_reg      <= left_b_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            count_a_reg     <= count_a_next;
            count_b_reg     <= count_b_next;
            overflow_reg    <= overflow_next;
            valid_reg       <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result_data  = result_reg;

    // The left edges never run more than one place past the element that is being added.
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_a_reg <= write_index_reg + ssk_pkg::IDX_W'(1))
        && (left_b_reg <= write_index_reg + ssk_pkg::IDX_W'(1)))
        else $error("window left edge ran past the newest element");

    // The buffer index never exceeds its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        write_index_reg <= ssk_pkg::IDX_W'(ssk_pkg::MAX_LENGTH))
        else $error("write index beyond buffer depth");

    // A result load leaves a cleared sequence behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (write_index_reg == '0) && !overflow_reg && (count_a_reg == '0))
        else $error("sequence state not cleared after result");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(valid_reg && !result_ready))
        else $error("result register overwritten");

endmodule

FILE: src/ssk_ctrl.sv
// Controller state machine that sequences add, shrink, count and emit steps.
module ssk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             elem_valid,
    output logic             elem_ready,
    input  logic             is_last,
    input  ssk_pkg::status_t status,
    output ssk_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SUB   = 3'd2;
    localparam logic [2:0] S_COUNT = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       accept;

    assign elem_ready = (state_reg == S_IDLE);
    assign accept     = elem_valid && elem_ready;

    // Step sequencing.
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = is_last;
                    if (status.room)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.ovf    = 1'b1;
                        state_next = is_last ? S_EMIT : S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                // The buffer read at each left edge is issued here.
                state_next = (status.need_a || status.need_b) ? S_SUB : S_COUNT;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_READ;
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Every shrink step is followed by a fresh read of the left edges.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB) |=> (state_reg == S_READ))
        else $error("shrink step not followed by read");

    // A shrink is only issued while some window is over its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub |-> (status.need_a || status.need_b))
        else $error("shrink issued with no window over limit");

endmodule

FILE: src/subarray_sum_equals_k_counter.sv
// Top level: APB target register, controller and datapath of the subarray sum counter.
//
//  Channel  | Signals                                  | Beat
//  ---------+------------------------------------------+-------------------------------
//  input    | elem_valid, elem_ready, elem_data        | one element, is_last marks end
//  output   | result_valid, result_ready, result_data  | count and overflow per sequence
//  config   | psel, penable, pwrite, paddr, pwdata,    | target_sum at word 0
//           | prdata, pready                           |
//
// An element that finds room passes through accept, left-edge read and count steps, with
// a shrink step and a fresh read for each element that leaves a window; both windows shrink
// in the same steps, so the extra cost is set by whichever window drops more elements, and
// each element leaves each window once; a result load step follows the last element.
// Reset clears all sequence state and the target; the element buffers need no clearing.
// A new element is taken while a result waits; only loading the next result waits on it.
module subarray_sum_equals_k_counter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        elem_valid,
    output logic                        elem_ready,
    input  ssk_pkg::elem_t              elem_data,
    output logic                        result_valid,
    input  logic                        result_ready,
    output ssk_pkg::result_t            result_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssk_pkg::PADDR_W-1:0] paddr,
    input  logic [ssk_pkg::PDATA_W-1:0] pwdata,
    output logic [ssk_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [ssk_pkg::TARGET_W-1:0] target_reg, target_next;
    logic                         reg_sel;
    ssk_pkg::cmd_t                cmd;
    ssk_pkg::status_t             status;

    // Register decode and write.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb
    begin
        target_next = target_reg;
        if (psel && penable && pwrite && (reg_sel == ssk_pkg::REG_TARGET))
        begin
            target_next = pwdata[ssk_pkg::TARGET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    // Register read.
    assign prdata = (reg_sel == ssk_pkg::REG_TARGET) ? ssk_pkg::PDATA_W'(target_reg) : '0;

    ssk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .is_last    (elem_data.is_last),
        .status     (status),
        .cmd        (cmd)
    );

    ssk_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .element      (elem_data.element),
        .target_sum   (target_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule
